### rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types, constants and helpers of the torus quad generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  localparam int SIDES_MAX     = 256;
  localparam int CORDIC_STAGES = 16;
  // one quotient bit per cell after the first compare
  localparam int DIV_CELLS     = 33;
  // stage index of the cordic start register in the tag line
  localparam int C0_IDX        = DIV_CELLS + 1;
  // tag line: start, divider, cordic start, cordic, map, three product stages
  localparam int PIPE_LEN      = C0_IDX + 1 + CORDIC_STAGES + 1 + 3;

  localparam logic signed [32:0] KINIT = 33'sd652032874;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RING_RADIUS = 2'd0,
    REG_TUBE_RADIUS = 2'd1,
    REG_RING_SIDES  = 2'd2,
    REG_TUBE_SIDES  = 2'd3
  } cfg_reg_t;

  // one lane of the long divider
  typedef struct packed {
    logic [8:0]  den;
    logic [7:0]  rem;
    logic [33:0] quo;
  } div_t;

  // one lane of the rotation cordic
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cordic_t;

  // control that travels with each corner request
  typedef struct packed {
    logic        valid;
    logic [1:0]  corner;
    logic        err;
    logic        last;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } tag_t;

  // geometry of one corner
  typedef struct packed {
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } vtx_t;

  // side count clamped to 3..SIDES_MAX
  function automatic logic [8:0] eff_sides(logic [8:0] s);
    logic [8:0] r;
    if (s < 9'd3) r = 9'd3;
    else if (s > 9'(SIDES_MAX)) r = 9'(SIDES_MAX);
    else r = s;
    return r;
  endfunction

  // atan(2^-i) in 2^-32 turns
  function automatic logic signed [32:0] atan_turn(logic [4:0] i);
    logic signed [32:0] v;
    unique case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // round half up then shift right
  function automatic logic signed [65:0] rnd_sh(logic signed [65:0] v, logic [5:0] n);
    logic signed [65:0] half;
    half = 66'sd1 <<< (n - 6'd1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [17:0] sat_pos(logic signed [65:0] v);
    logic signed [17:0] r;
    if (v < -66'sd131072) r = -18'sd131072;
    else if (v > 66'sd131071) r = 18'sd131071;
    else r = v[17:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat_norm(logic signed [65:0] v);
    logic signed [15:0] r;
    if (v < -66'sd16384) r = -16'sd16384;
    else if (v > 66'sd16384) r = 16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/torus_mesh_quad_generator_top.sv
// ----------------------------------------------------------------------------
// torus_mesh_quad_generator_top
// Emits the four corners of one torus quad: position, normal, texture coords.
// ----------------------------------------------------------------------------
// One request (ring step, tube step) yields four corner results, or a single
// result with index_error set when a step is not below its side count. While
// the output register is not stalled, the pipeline issues one corner per cycle
// and the result channel carries one corner per cycle; a new request is taken
// as the last corner of the current one issues. A request passes the angle
// divider, the cordic start register and a 16-cell cordic chain per angle, the
// fold and product stages, plus the output register. The whole pipeline holds
// while the output register is full and not taken. Configuration must be
// written only while no request is in flight; the block does not enforce this.
`default_nettype none

module torus_mesh_quad_generator_top (
  input  wire          clk,
  input  wire          rst_n,
  // configuration write port
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [15:0]  cfg_wdata,
  // request channel
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [15:0]  in_tdata,   // ring_step[7:0], tube_step[15:8]
  // result channel
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [143:0] out_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                   // tex_u, tex_v, corner, zero pad
  output logic         out_tuser,  // index_error
  output logic         out_tlast   // last_corner
);
  import tmq_pkg::*;

  logic [15:0] ring_radius_r, tube_radius_r;
  logic [8:0]  ring_sides_r, tube_sides_r;
  logic [8:0]  n1, n2;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_radius_r <= 16'd1280;
      tube_radius_r <= 16'd512;
      ring_sides_r  <= 9'd32;
      tube_sides_r  <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RING_RADIUS: ring_radius_r <= cfg_wdata;
        REG_TUBE_RADIUS: tube_radius_r <= cfg_wdata;
        REG_RING_SIDES:  ring_sides_r  <= cfg_wdata[8:0];
        REG_TUBE_SIDES:  tube_sides_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign n1 = eff_sides(ring_sides_r);
  assign n2 = eff_sides(tube_sides_r);

  // request sequencer: one corner issued per advancing cycle
  logic       busy_r, busy_nxt;
  logic [7:0] a_r, b_r;
  logic       err_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       last_issue, issue, accept;

  assign last_issue = err_r || (cnt_r == 2'd3);
  assign issue      = busy_r && en;
  assign in_tready  = !busy_r || (issue && last_issue);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (issue) begin
      cnt_nxt = cnt_r + 2'd1;
      if (last_issue) busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r   <= in_tdata[7:0];
      b_r   <= in_tdata[15:8];
      err_r <= ({1'b0, in_tdata[7:0]} >= n1) || ({1'b0, in_tdata[15:8]} >= n2);
    end
  end

  // corner step indexes and first divider compare
  logic [8:0] ka, kb;
  div_t       ring_div [DIV_CELLS+1];
  div_t       tube_div [DIV_CELLS+1];

  assign ka = (cnt_r == 2'd0 || cnt_r == 2'd1) ? {1'b0, a_r} + 9'd1 : {1'b0, a_r};
  assign kb = (cnt_r == 2'd1 || cnt_r == 2'd2) ? {1'b0, b_r} + 9'd1 : {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ring_div[0].den <= n1;
      ring_div[0].rem <= (ka >= n1) ? 8'(ka - n1) : ka[7:0];
      ring_div[0].quo <= {33'b0, ka >= n1};
      tube_div[0].den <= n2;
      tube_div[0].rem <= (kb >= n2) ? 8'(kb - n2) : kb[7:0];
      tube_div[0].quo <= {33'b0, kb >= n2};
    end
  end

  // divider chains: quotient of k * 2^33 by the side count
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    tmq_div_cell u_ring (.clk(clk), .en(en), .d_in(ring_div[i]), .d_out(ring_div[i+1]));
    tmq_div_cell u_tube (.clk(clk), .en(en), .d_in(tube_div[i]), .d_out(tube_div[i+1]));
  end

  // rounded turn fraction and texture coordinate from the quotient
  logic [34:0] ring_q1, tube_q1;
  logic [18:0] ring_t1, tube_t1;
  logic [16:0] ring_tex, tube_tex;

  assign ring_q1  = {1'b0, ring_div[DIV_CELLS].quo} + 35'd1;
  assign tube_q1  = {1'b0, tube_div[DIV_CELLS].quo} + 35'd1;
  assign ring_t1  = {1'b0, ring_div[DIV_CELLS].quo[33:16]} + 19'd1;
  assign tube_t1  = {1'b0, tube_div[DIV_CELLS].quo[33:16]} + 19'd1;
  assign ring_tex = ring_t1[17:1];
  assign tube_tex = tube_t1[17:1];

  cordic_t ring_c [CORDIC_STAGES+1];
  cordic_t tube_c [CORDIC_STAGES+1];

  // cordic start values
  always_ff @(posedge clk) begin
    if (en) begin
      ring_c[0].x    <= KINIT;
      ring_c[0].y    <= 33'sd0;
      ring_c[0].z    <= $signed({3'b0, ring_q1[30:1]});
      ring_c[0].quad <= ring_q1[32:31];
      tube_c[0].x    <= KINIT;
      tube_c[0].y    <= 33'sd0;
      tube_c[0].z    <= $signed({3'b0, tube_q1[30:1]});
      tube_c[0].quad <= tube_q1[32:31];
    end
  end

  // cordic chains
  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    tmq_cordic_cell u_ring (.clk(clk), .en(en), .step(5'(j)),
                            .c_in(ring_c[j]), .c_out(ring_c[j+1]));
    tmq_cordic_cell u_tube (.clk(clk), .en(en), .step(5'(j)),
                            .c_in(tube_c[j]), .c_out(tube_c[j+1]));
  end

  // position and normal products
  vtx_t vtx;

  tmq_vertex_math u_math (
    .clk         (clk),
    .en          (en),
    .ring_in     (ring_c[CORDIC_STAGES]),
    .tube_in     (tube_c[CORDIC_STAGES]),
    .ring_radius (ring_radius_r),
    .tube_radius (tube_radius_r),
    .vtx         (vtx)
  );

  // tag line alongside the data path
  tag_t tag_r [PIPE_LEN];
  tag_t tag_in;
  tag_t tag_c0;

  always_comb begin
    tag_in.valid  = issue;
    tag_in.corner = err_r ? 2'd0 : cnt_r;
    tag_in.err    = err_r;
    tag_in.last   = last_issue;
    tag_in.tex_u  = 17'd0;
    tag_in.tex_v  = 17'd0;
  end

  // texture coordinates join the tag beside the cordic start
  always_comb begin
    tag_c0       = tag_r[C0_IDX-1];
    tag_c0.tex_u = 17'd65536 - ring_tex;
    tag_c0.tex_v = tube_tex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LEN; i++) tag_r[i].valid <= 1'b0;
    end else if (en) begin
      tag_r[0] <= tag_in;
      for (int i = 1; i < PIPE_LEN; i++) begin
        if (i != C0_IDX) tag_r[i] <= tag_r[i-1];
      end
      tag_r[C0_IDX] <= tag_c0;
    end
  end

  // output register
  logic  out_valid_r;
  vtx_t  out_vtx_r;
  logic [16:0] out_u_r, out_v_r;
  logic [1:0]  out_corner_r;
  logic        out_err_r, out_last_r;

  assign en = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_r[PIPE_LEN-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err_r    <= tag_r[PIPE_LEN-1].err;
      out_last_r   <= tag_r[PIPE_LEN-1].last;
      out_corner_r <= tag_r[PIPE_LEN-1].corner;
      if (tag_r[PIPE_LEN-1].err) begin
        out_vtx_r <= '0;
        out_u_r   <= 17'd0;
        out_v_r   <= 17'd0;
      end else begin
        out_vtx_r <= vtx;
        out_u_r   <= tag_r[PIPE_LEN-1].tex_u;
        out_v_r   <= tag_r[PIPE_LEN-1].tex_v;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_corner_r, out_v_r, out_u_r,
                       out_vtx_r.norm_z, out_vtx_r.norm_y, out_vtx_r.norm_x,
                       out_vtx_r.pos_z, out_vtx_r.pos_y, out_vtx_r.pos_x};

endmodule

`default_nettype wire

### rtl/tmq_div_cell.sv
// ----------------------------------------------------------------------------
// tmq_div_cell
// One restoring step of the angle divider: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_div_cell (
  input  wire            clk,
  input  wire            en,
  input  tmq_pkg::div_t  d_in,
  output tmq_pkg::div_t  d_out
);
  import tmq_pkg::*;

  logic [8:0] dbl;
  logic       ge;
  div_t       d_nxt;
  div_t       d_r;

  // shift remainder, compare, subtract
  always_comb begin
    dbl         = {d_in.rem, 1'b0};
    ge          = (dbl >= d_in.den);
    d_nxt.den   = d_in.den;
    d_nxt.rem   = ge ? 8'(dbl - d_in.den) : dbl[7:0];
    d_nxt.quo   = {d_in.quo[32:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

`default_nettype wire

### rtl/tmq_cordic_cell.sv
// ----------------------------------------------------------------------------
// tmq_cordic_cell
// One rotation step of the sine and cosine cordic.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_cordic_cell (
  input  wire              clk,
  input  wire              en,
  input  wire  [4:0]       step,
  input  tmq_pkg::cordic_t c_in,
  output tmq_pkg::cordic_t c_out
);
  import tmq_pkg::*;

  cordic_t c_nxt;
  cordic_t c_r;

  // rotate toward zero residual angle
  always_comb begin
    c_nxt.quad = c_in.quad;
    if (!c_in.z[32]) begin
      c_nxt.x = c_in.x - (c_in.y >>> step);
      c_nxt.y = c_in.y + (c_in.x >>> step);
      c_nxt.z = c_in.z - atan_turn(step);
    end else begin
      c_nxt.x = c_in.x + (c_in.y >>> step);
      c_nxt.y = c_in.y - (c_in.x >>> step);
      c_nxt.z = c_in.z + atan_turn(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

`default_nettype wire

### rtl/tmq_vertex_math.sv
// ----------------------------------------------------------------------------
// tmq_vertex_math
// Quadrant fold and products that turn sine and cosine into position and normal.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_vertex_math (
  input  wire              clk,
  input  wire              en,
  input  tmq_pkg::cordic_t ring_in,
  input  tmq_pkg::cordic_t tube_in,
  input  wire  [15:0]      ring_radius,
  input  wire  [15:0]      tube_radius,
  output tmq_pkg::vtx_t    vtx
);
  import tmq_pkg::*;

  localparam logic signed [50:0] W_HALF = 51'sd2097152;

  logic signed [32:0] ca_nxt, sa_nxt, cb_nxt, sb_nxt;
  logic signed [32:0] ca_r, sa_r, cb_r, sb_r;
  logic signed [32:0] ca1_r, sa1_r, ca2_r, sa2_r;
  logic signed [49:0] mw_r, py_p_r;
  logic signed [65:0] nx_p_r, nz_p_r;
  logic signed [15:0] ny1_r, ny2_r, ny3_r, nx2_r, nz2_r, nx3_r, nz3_r;
  logic signed [17:0] py2_r, py3_r;
  logic signed [50:0] acc;
  logic signed [65:0] w_wide;
  logic signed [27:0] w_r;
  logic signed [65:0] px_p_r, pz_p_r;
  logic signed [65:0] ny_ext, py_ext;

  // fold quadrant back onto cosine and sine
  always_comb begin
    unique case (ring_in.quad)
      2'd0: begin ca_nxt = ring_in.x;  sa_nxt = ring_in.y;  end
      2'd1: begin ca_nxt = -ring_in.y; sa_nxt = ring_in.x;  end
      2'd2: begin ca_nxt = -ring_in.x; sa_nxt = -ring_in.y; end
      default: begin ca_nxt = ring_in.y; sa_nxt = -ring_in.x; end
    endcase
    unique case (tube_in.quad)
      2'd0: begin cb_nxt = tube_in.x;  sb_nxt = tube_in.y;  end
      2'd1: begin cb_nxt = -tube_in.y; sb_nxt = tube_in.x;  end
      2'd2: begin cb_nxt = -tube_in.x; sb_nxt = -tube_in.y; end
      default: begin cb_nxt = tube_in.y; sb_nxt = -tube_in.x; end
    endcase
  end

  // tube offset, normal products and ring distance
  always_comb begin
    ny_ext = 66'(sb_r);
    py_ext = 66'(py_p_r);
    acc    = $signed({5'b0, ring_radius, 30'b0}) + 51'(mw_r);
    w_wide = 66'((acc + W_HALF) >>> 22);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fold stage
      ca_r   <= ca_nxt;
      sa_r   <= sa_nxt;
      cb_r   <= cb_nxt;
      sb_r   <= sb_nxt;
      // first product stage
      mw_r   <= 50'($signed({1'b0, tube_radius})) * 50'(cb_r);
      py_p_r <= 50'($signed({1'b0, tube_radius})) * 50'(sb_r);
      nx_p_r <= 66'(cb_r) * 66'(ca_r);
      nz_p_r <= 66'(cb_r) * 66'(sa_r);
      ny1_r  <= sat_norm(rnd_sh(ny_ext, 6'd16));
      ca1_r  <= ca_r;
      sa1_r  <= sa_r;
      // rounding stage
      w_r    <= w_wide[27:0];
      nx2_r  <= sat_norm(rnd_sh(nx_p_r, 6'd46));
      nz2_r  <= sat_norm(rnd_sh(nz_p_r, 6'd46));
      py2_r  <= sat_pos(rnd_sh(py_ext, 6'd30));
      ny2_r  <= ny1_r;
      ca2_r  <= ca1_r;
      sa2_r  <= sa1_r;
      // second product stage
      px_p_r <= 66'(w_r) * 66'(ca2_r);
      pz_p_r <= 66'(w_r) * 66'(sa2_r);
      nx3_r  <= nx2_r;
      nz3_r  <= nz2_r;
      ny3_r  <= ny2_r;
      py3_r  <= py2_r;
    end
  end

  always_comb begin
    vtx.pos_x  = sat_pos(rnd_sh(px_p_r, 6'd38));
    vtx.pos_z  = sat_pos(rnd_sh(pz_p_r, 6'd38));
    vtx.pos_y  = py3_r;
    vtx.norm_x = nx3_r;
    vtx.norm_y = ny3_r;
    vtx.norm_z = nz3_r;
  end

endmodule

`default_nettype wire

### rtl/tmq_checker.sv
// ----------------------------------------------------------------------------
// tmq_checker
// Port-level checks of the torus quad generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_checker (
  input wire          clk,
  input wire          rst_n,
  input wire          cfg_we,
  input wire  [1:0]   cfg_addr,
  input wire  [15:0]  cfg_wdata,
  input wire          in_tvalid,
  input wire          in_tready,
  input wire  [15:0]  in_tdata,
  input wire          out_tvalid,
  input wire          out_tready,
  input wire  [143:0] out_tdata,
  input wire          out_tuser,
  input wire          out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // error result is a lone last result with cleared corner
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[137:136] == 2'd0))
    else $error("error result malformed");

  // last marks exactly the fourth corner of a good quad
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tlast == (out_tdata[137:136] == 2'd3)))
    else $error("last flag out of step with corner");

  // x and y normals stay within unit range
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[69:54]) >= -16'sd16384)
      && ($signed(out_tdata[69:54]) <= 16'sd16384)
      && ($signed(out_tdata[85:70]) >= -16'sd16384)
      && ($signed(out_tdata[85:70]) <= 16'sd16384))
    else $error("normal out of range");

  // ready is known, and request and register writes carry known values
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_tready) && (!in_tvalid || !$isunknown(in_tdata))
      && (!cfg_we || !$isunknown({cfg_addr, cfg_wdata})))
    else $error("unknown value on request or configuration port");

endmodule

bind torus_mesh_quad_generator_top tmq_checker u_tmq_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the torus quad generator: requests carry a quad
// address, results are compared with a bit-exact fixed point corner predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmq_pkg::*;

  localparam int FLUSH_CYCLES = 80;

  // corner record as it leaves the block
  typedef struct {
    logic signed [17:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [16:0]        tex_u, tex_v;
    logic [1:0]         corner;
    logic               index_error;
    logic               last_corner;
  } corner_rec_t;

  // directed request row, err_known marks an address typed in as out of range
  typedef struct {
    logic [7:0] ring_step;
    logic [7:0] tube_step;
    bit         err_known;
  } quad_row_t;

  // one register setting of the whole block
  typedef struct {
    logic [15:0] ring_r, tube_r, ring_n, tube_n;
  } torus_cfg_t;

  localparam longint ATAN_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;   // ring_step[7:0], tube_step[15:8]
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [143:0] out_tdata;       // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                 // tex_u, tex_v, corner, zero pad
  logic         out_tuser;       // index_error
  logic         out_tlast;       // last_corner

  // predictor copy of the registers
  longint unsigned ring_radius_q = 1280, tube_radius_q = 512;
  logic [8:0]      ring_sides_q = 9'd32, tube_sides_q = 9'd16;

  corner_rec_t pending_corners [$];
  int          fail_cnt = 0;
  int          corners_seen = 0;
  int          requests_sent = 0;
  int          error_quads = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  torus_mesh_quad_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout with %0d corners outstanding", pending_corners.size());
    $display("** torus_mesh_quad_generator_top: FAILED **");
    $finish;
  end

  function automatic logic [8:0] clamp_sides(logic [8:0] s);
    if (s < 9'd3) return 9'd3;
    if (s > 9'd256) return 9'd256;
    return s;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // step count to fraction of a turn, 2^-32 units
  function automatic logic [31:0] step_angle(longint unsigned k, longint unsigned n);
    longint unsigned q;
    q = ((k << 33) + n) / (2 * n);
    return q[31:0];
  endfunction

  function automatic longint unsigned tex_frac(longint unsigned k, longint unsigned n);
    return ((k << 17) + n) / (2 * n);
  endfunction

  // rotation cordic in turns, Q.30 outputs
  task automatic cordic_sin_cos(input logic [31:0] th, output longint c, output longint s);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    z = longint'(th[29:0]);
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURN[i];
      end
      x = nx;
    end
    case (th[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic corner_rec_t range_error_rec();
    corner_rec_t r;
    r = '{default: '0};
    r.index_error = 1'b1;
    r.last_corner = 1'b1;
    return r;
  endfunction

  // queue the corners of one quad
  task automatic predict_quad(logic [7:0] a, logic [7:0] b);
    longint unsigned n1, n2, ka, kb;
    longint ca, sa, cb, sb, w;
    corner_rec_t r;
    n1 = clamp_sides(ring_sides_q);
    n2 = clamp_sides(tube_sides_q);
    if (a >= n1 || b >= n2) begin
      pending_corners.push_back(range_error_rec());
      error_quads++;
    end else begin
      for (int k = 0; k < 4; k++) begin
        ka = (k < 2) ? a + 1 : a;
        kb = (k == 1 || k == 2) ? b + 1 : b;
        cordic_sin_cos(step_angle(ka, n1), ca, sa);
        cordic_sin_cos(step_angle(kb, n2), cb, sb);
        w = round_shift((longint'(ring_radius_q) <<< 30) + longint'(tube_radius_q) * cb, 22);
        r.pos_x  = 18'(clip(round_shift(w * ca, 38), -131072, 131071));
        r.pos_z  = 18'(clip(round_shift(w * sa, 38), -131072, 131071));
        r.pos_y  = 18'(clip(round_shift(longint'(tube_radius_q) * sb, 30), -131072, 131071));
        r.norm_x = 16'(clip(round_shift(cb * ca, 46), -16384, 16384));
        r.norm_y = 16'(clip(round_shift(sb, 16), -16384, 16384));
        r.norm_z = 16'(clip(round_shift(cb * sa, 46), -16384, 16384));
        r.tex_u  = 17'(65536 - tex_frac(ka, n1));
        r.tex_v  = 17'(tex_frac(kb, n2));
        r.corner = 2'(k);
        r.index_error = 1'b0;
        r.last_corner = (k == 3);
        pending_corners.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] corner %0d %s: got %0d expected %0d", $realtime, corners_seen, what, got,
             want);
    fail_cnt++;
  endtask

  // result check and random back-pressure
  always @(posedge clk) begin
    corner_rec_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.pos_x  = out_tdata[17:0];
        got.pos_y  = out_tdata[35:18];
        got.pos_z  = out_tdata[53:36];
        got.norm_x = out_tdata[69:54];
        got.norm_y = out_tdata[85:70];
        got.norm_z = out_tdata[101:86];
        got.tex_u  = out_tdata[118:102];
        got.tex_v  = out_tdata[135:119];
        got.corner = out_tdata[137:136];
        got.index_error = out_tuser;
        got.last_corner = out_tlast;
        if (pending_corners.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_corners.pop_front();
          if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.pos_z !== want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
          if (got.norm_x !== want.norm_x) report_mismatch("norm_x", got.norm_x, want.norm_x);
          if (got.norm_y !== want.norm_y) report_mismatch("norm_y", got.norm_y, want.norm_y);
          if (got.norm_z !== want.norm_z) report_mismatch("norm_z", got.norm_z, want.norm_z);
          if (got.tex_u !== want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
          if (got.tex_v !== want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
          if (got.corner !== want.corner) report_mismatch("corner", got.corner, want.corner);
          if (got.index_error !== want.index_error)
            report_mismatch("index_error", got.index_error, want.index_error);
          if (got.last_corner !== want.last_corner)
            report_mismatch("last_corner", got.last_corner, want.last_corner);
        end
        corners_seen++;
        stall_left = calm ? 0 : $urandom_range(0, 17);
        if (stall_left > 0) out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (stall_left <= 1) out_tready <= 1'b1;
        stall_left--;
      end
    end
  end

  // stimulus
  initial begin
    quad_row_t   quad_rows [$];
    torus_cfg_t  phase_cfg [$];
    torus_cfg_t  pc;
    int          gap;
    logic [7:0]  a, b;
    int          n1, n2;

    // directed quads at the reset setting: corners of the grid and bad addresses
    quad_rows = '{
      '{8'd0,   8'd0,   1'b0}, '{8'd31,  8'd15,  1'b0}, '{8'd31, 8'd0,  1'b0},
      '{8'd0,   8'd15,  1'b0}, '{8'd16,  8'd8,   1'b0}, '{8'd8,  8'd4,  1'b0},
      '{8'd24,  8'd12,  1'b0}, '{8'd7,   8'd11,  1'b0},
      '{8'd32,  8'd0,   1'b1}, '{8'd0,   8'd16,  1'b1}, '{8'd255, 8'd255, 1'b1},
      '{8'd255, 8'd0,   1'b1}, '{8'd0,   8'd255, 1'b1}, '{8'd170, 8'd85,  1'b1}};

    // register settings: full sides, extremes, clamped counts, tube above ring
    phase_cfg = '{
      '{16'd1280,  16'd512,   16'd256, 16'd256},
      '{16'd65535, 16'd65535, 16'd3,   16'd3},
      '{16'd1,     16'd1,     16'd0,   16'd2},
      '{16'd65535, 16'd1,     16'd511, 16'd300},
      '{16'd3000,  16'd4000,  16'd7,   16'd200},
      '{16'd0,     16'd0,     16'd100, 16'd37},
      '{16'd0,     16'd0,     16'd0,   16'd0}};
    phase_cfg[6].ring_r = $urandom_range(1, 65535);
    phase_cfg[6].tube_r = $urandom_range(1, phase_cfg[6].ring_r);
    phase_cfg[6].ring_n = $urandom_range(3, 256);
    phase_cfg[6].tube_n = $urandom_range(3, 256);

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (quad_rows[i]) begin
      gap = $urandom_range(0, 17);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {quad_rows[i].tube_step, quad_rows[i].ring_step};
      do @(posedge clk); while (!in_tready);
      requests_sent++;
      if (quad_rows[i].err_known) begin
        pending_corners.push_back(range_error_rec());
        error_quads++;
      end else begin
        predict_quad(quad_rows[i].ring_step, quad_rows[i].tube_step);
      end
    end

    foreach (phase_cfg[p]) begin
      // hold off until the block has drained, then reprogram
      in_tvalid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clk);
      repeat (FLUSH_CYCLES) @(posedge clk);
      pc = phase_cfg[p];
      cfg_we <= 1'b1;
      cfg_addr <= REG_RING_RADIUS; cfg_wdata <= pc.ring_r; @(posedge clk);
      cfg_addr <= REG_TUBE_RADIUS; cfg_wdata <= pc.tube_r; @(posedge clk);
      cfg_addr <= REG_RING_SIDES;  cfg_wdata <= pc.ring_n; @(posedge clk);
      cfg_addr <= REG_TUBE_SIDES;  cfg_wdata <= pc.tube_n; @(posedge clk);
      cfg_we <= 1'b0;
      ring_radius_q = pc.ring_r;
      tube_radius_q = pc.tube_r;
      ring_sides_q  = pc.ring_n[8:0];
      tube_sides_q  = pc.tube_n[8:0];
      n1 = clamp_sides(ring_sides_q);
      n2 = clamp_sides(tube_sides_q);
      calm = (p == 1);

      // mostly in-range quads, some random addresses that may overrun
      for (int i = 0; i < 37; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          a = $urandom_range(0, n1 - 1);
          b = $urandom_range(0, n2 - 1);
        end else begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= {b, a};
        do @(posedge clk); while (!in_tready);
        requests_sent++;
        predict_quad(a, b);
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // drain and settle
    while (pending_corners.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (pending_corners.size() != 0)
      report_mismatch("corners left over", pending_corners.size(), 0);

    $display("%0d quad requests (%0d out of range) over %0d register settings,",
             requests_sent, error_quads, phase_cfg.size() + 1);
    $display("%0d corners checked with random gaps and stalls, %0d mismatches",
             corners_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("** torus_mesh_quad_generator_top: PASSED **");
    end else begin
      $display("** torus_mesh_quad_generator_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
